// ===== rtl/asst_pkg.sv =====
package asst_pkg;

  localparam int unsigned StepW  = 32;
  localparam int unsigned ModW   = 18;
  localparam int unsigned RateW  = 17;
  localparam int unsigned CntW   = 16;
  localparam int unsigned ProdW  = StepW + ModW;
  localparam int unsigned DivW   = StepW + 16;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [CntW-1:0]  Window    = 16'd200;
  localparam logic [CntW-1:0]  CntMax    = 16'hFFFF;
  localparam logic [ModW-1:0]  OneQ16    = 18'd65536;
  localparam logic [ModW-1:0]  ModReset  = 18'd104858;
  localparam logic [ModW-1:0]  MaxMod    = 18'd131072;
  localparam logic [ModW-1:0]  ShrinkQ16 = 18'd45875;
  localparam logic [ProdW-1:0] RoundHalf = 50'd32768;

  localparam logic [1:0] DirNone = 2'd0;
  localparam logic [1:0] DirUp   = 2'd1;
  localparam logic [1:0] DirDown = 2'd2;

  localparam logic [1:0] OpPropose  = 2'd0;
  localparam logic [1:0] OpValidate = 2'd1;
  localparam logic [1:0] OpStop     = 2'd2;

  localparam logic [2:0] RegMinAcc  = 3'd0;
  localparam logic [2:0] RegMaxAcc  = 3'd1;
  localparam logic [2:0] RegMinStep = 3'd2;
  localparam logic [2:0] RegMaxStep = 3'd3;
  localparam logic [2:0] RegInit    = 3'd4;

  typedef struct packed {
    logic [StepW-1:0] step;
    logic [ModW-1:0]  modifier;
    logic             closed;
    logic             adapting;
    logic [CntW-1:0]  proposals;
    logic [CntW-1:0]  accepts;
  } res_t;

endpackage

// ===== rtl/asst_mul.sv =====
module asst_mul (
  input  logic                         clk_i,
  input  logic [asst_pkg::StepW-1:0]   a_i,
  input  logic [asst_pkg::ModW-1:0]    b_i,
  output logic [asst_pkg::ProdW-1:0]   p_o
);
  import asst_pkg::*;

  logic [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/asst_div.sv =====
module asst_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [asst_pkg::DivW-1:0]  dividend_i,
  input  logic [asst_pkg::ModW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [asst_pkg::DivW-1:0]  quot_o
);
  import asst_pkg::*;

  localparam int unsigned CntBits = $clog2(DivW);
  localparam logic [CntBits-1:0] LastStep = CntBits'(DivW - 1);

  logic               busy_q, done_q;
  logic [CntBits-1:0] cnt_q;
  logic [ModW-1:0]    rem_q, div_q;
  logic [DivW-1:0]    quot_q;
  logic [ModW:0]      shifted, trial;
  logic               fits;

  assign shifted = {rem_q, quot_q[DivW-1]};
  assign trial   = shifted - {1'b0, div_q};
  assign fits    = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      div_q  <= divisor_i;
      quot_q <= dividend_i;
    end else if (busy_q) begin
      rem_q  <= fits ? trial[ModW-1:0] : shifted[ModW-1:0];
      quot_q <= {quot_q[DivW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/adaptive_step_size_tuner.sv =====
// Adaptive step-size tuner. Each input word is an event (propose, validate,
// stop burn-in) and yields exactly one result word with the working step,
// the modifier, the window counters and the adaptation status. Proposes,
// stops and validates that do not close a window go straight from idle to
// their result. A validate that closes an adaptation window runs a sequencer
// over one shared 32x18 multiplier and a radix-2 divider: it compares the
// accepts with both band limits, shrinks the modifier when the direction
// reverses, then steps up by a multiply or down by a 48-step divide.
// The input is not ready while a window is being closed. An output register
// plus one skid register let a new event enter while a result waits.
// Configuration writes are taken through the APB port at any time but are
// meant to be made while the block is idle.
module adaptive_step_size_tuner (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [asst_pkg::AddrW-1:0]  paddr,
  input  logic [asst_pkg::DataW-1:0]  pwdata,
  output logic [asst_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  op_i,
  input  logic                        accepted_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [asst_pkg::StepW-1:0]  current_step_o,
  output logic [asst_pkg::ModW-1:0]   current_modifier_o,
  output logic                        window_closed_o,
  output logic                        adapting_o,
  output logic [asst_pkg::CntW-1:0]   proposals_seen_o,
  output logic [asst_pkg::CntW-1:0]   accepts_seen_o
);
  import asst_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SMulHi = 4'd1;
  localparam logic [3:0] SMulLo = 4'd2;
  localparam logic [3:0] SDec   = 4'd3;
  localparam logic [3:0] SShr   = 4'd4;
  localparam logic [3:0] SShrWb = 4'd5;
  localparam logic [3:0] SUp    = 4'd6;
  localparam logic [3:0] SUpWb  = 4'd7;
  localparam logic [3:0] SDivGo = 4'd8;
  localparam logic [3:0] SDivWt = 4'd9;
  localparam logic [3:0] SFin   = 4'd10;

  logic [RateW-1:0] min_acc_q, max_acc_q;
  logic [StepW-1:0] min_step_q, max_step_q, init_step_q;
  logic [StepW-1:0] step_q, step_d;
  logic [ModW-1:0]  mod_q, mod_d;
  logic [1:0]       dir_q, dir_d;
  logic [CntW-1:0]  prop_q, prop_d, acc_q, acc_d;
  logic             adapt_q, adapt_d;
  logic [3:0]       state_q, state_d;
  logic             gt_q, gt_d, up_q, up_d;

  logic             out_valid_q, skid_valid_q;
  res_t             out_q, skid_q, res_new;
  logic             push;

  logic             cfg_wr;
  logic [2:0]       cfg_idx;
  logic             in_fire, fixed_band, closing;
  logic [StepW-1:0] mul_a;
  logic [ModW-1:0]  mul_b;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] acc_scaled, rounded;
  logic [ModW-1:0]  excess, divisor;
  logic             div_start, div_done;
  logic [DivW-1:0]  quot;
  logic [StepW-1:0] step_hi, step_clamped;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[AddrW-1:2];

  always_comb begin
    unique case (cfg_idx)
      RegMinAcc:  prdata = DataW'(min_acc_q);
      RegMaxAcc:  prdata = DataW'(max_acc_q);
      RegMinStep: prdata = min_step_q;
      RegMaxStep: prdata = max_step_q;
      RegInit:    prdata = init_step_q;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_acc_q   <= 17'd13107;
      max_acc_q   <= 17'd16384;
      min_step_q  <= '0;
      max_step_q  <= '1;
      init_step_q <= StepW'(OneQ16);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegMinAcc:  min_acc_q   <= pwdata[RateW-1:0];
        RegMaxAcc:  max_acc_q   <= pwdata[RateW-1:0];
        RegMinStep: min_step_q  <= pwdata;
        RegMaxStep: max_step_q  <= pwdata;
        RegInit:    init_step_q <= pwdata;
        default: ;
      endcase
    end
  end

  assign fixed_band = (min_acc_q == '0) && (max_acc_q == RateW'(OneQ16));
  assign in_ready_o = (state_q == SIdle) && !skid_valid_q;
  assign in_fire    = in_valid_i & in_ready_o;
  assign closing    = (op_i == OpValidate) && adapt_q && !fixed_band && (prop_q == Window);

  always_comb begin
    mul_a = StepW'(max_acc_q);
    mul_b = ModW'(prop_q);
    unique case (state_q)
      SMulLo:  begin
        mul_a = StepW'(min_acc_q);
        mul_b = ModW'(prop_q);
      end
      SShr:    begin
        mul_a = StepW'(excess);
        mul_b = ShrinkQ16;
      end
      SUp:     begin
        mul_a = step_q;
        mul_b = mod_q;
      end
      default: ;
    endcase
  end

  asst_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign divisor   = (mod_q == '0) ? ModW'(1) : mod_q;
  assign div_start = (state_q == SDivGo);

  asst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({step_q, 16'd0}),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign acc_scaled   = {18'd0, acc_q, 16'd0};
  assign excess       = (mod_q > OneQ16) ? (mod_q - OneQ16) : '0;
  assign rounded      = prod + RoundHalf;
  assign step_hi      = (prod[ProdW-1:ProdW-2] != 2'b00) ? '1 : prod[ProdW-3:16];
  assign step_clamped = (((step_q > max_step_q) ? max_step_q : step_q) < min_step_q) ?
                        min_step_q : ((step_q > max_step_q) ? max_step_q : step_q);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    mod_d   = mod_q;
    dir_d   = dir_q;
    prop_d  = prop_q;
    acc_d   = acc_q;
    adapt_d = adapt_q;
    gt_d    = gt_q;
    up_d    = up_q;
    push    = 1'b0;
    res_new = '0;
    unique case (state_q)
      SIdle: begin
        if (in_fire) begin
          case (op_i)
            OpPropose: begin
              if (prop_q != CntMax) begin
                prop_d = prop_q + 1'b1;
              end
            end
            OpValidate: begin
              if (accepted_i && acc_q != CntMax) begin
                acc_d = acc_q + 1'b1;
              end
            end
            OpStop: begin
              adapt_d = 1'b0;
              prop_d  = '0;
              acc_d   = '0;
            end
            default: ;
          endcase
          if (closing) begin
            state_d = SMulHi;
          end else begin
            push = 1'b1;
          end
        end
      end
      SMulHi: state_d = SMulLo;
      SMulLo: begin
        gt_d    = acc_scaled > prod;
        state_d = SDec;
      end
      SDec: begin
        if (gt_q) begin
          up_d    = 1'b1;
          state_d = (dir_q == DirDown) ? SShr : SUp;
        end else if (acc_scaled < prod) begin
          up_d    = 1'b0;
          state_d = (dir_q == DirUp) ? SShr : SDivGo;
        end else begin
          state_d = SFin;
        end
      end
      SShr: state_d = SShrWb;
      SShrWb: begin
        mod_d   = OneQ16 + rounded[ModW+15:16];
        state_d = up_q ? SUp : SDivGo;
      end
      SUp: state_d = SUpWb;
      SUpWb: begin
        step_d  = step_hi;
        dir_d   = DirUp;
        state_d = SFin;
      end
      SDivGo: state_d = SDivWt;
      SDivWt: begin
        if (div_done) begin
          step_d  = quot[StepW-1:0];
          dir_d   = DirDown;
          state_d = SFin;
        end
      end
      SFin: begin
        step_d  = step_clamped;
        prop_d  = '0;
        acc_d   = '0;
        push    = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
    if (cfg_wr && cfg_idx == RegInit) begin
      step_d = pwdata;
    end
    res_new.step      = step_d;
    res_new.modifier  = mod_d;
    res_new.closed    = (state_q == SFin);
    res_new.adapting  = adapt_d & ~fixed_band;
    res_new.proposals = prop_d;
    res_new.accepts   = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      step_q  <= StepW'(OneQ16);
      mod_q   <= ModReset;
      dir_q   <= DirNone;
      prop_q  <= '0;
      acc_q   <= '0;
      adapt_q <= 1'b1;
      gt_q    <= 1'b0;
      up_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      mod_q   <= mod_d;
      dir_q   <= dir_d;
      prop_q  <= prop_d;
      acc_q   <= acc_d;
      adapt_q <= adapt_d;
      gt_q    <= gt_d;
      up_q    <= up_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= res_new;
        end
      end else if (push) begin
        out_q <= res_new;
      end
    end else if (push) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign current_step_o     = out_q.step;
  assign current_modifier_o = out_q.modifier;
  assign window_closed_o    = out_q.closed;
  assign adapting_o         = out_q.adapting;
  assign proposals_seen_o   = out_q.proposals;
  assign accepts_seen_o     = out_q.accepts;

endmodule

// ===== rtl/asst_checker.sv =====
module asst_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [asst_pkg::ModW-1:0]   current_modifier_o,
  input logic                        window_closed_o,
  input logic                        adapting_o,
  input logic [asst_pkg::CntW-1:0]   proposals_seen_o,
  input logic [asst_pkg::CntW-1:0]   accepts_seen_o
);
  import asst_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped before it was taken");

  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (current_modifier_o >= OneQ16) && (current_modifier_o <= MaxMod))
    else $error("modifier out of range");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_closed_o |-> (proposals_seen_o == '0) && (accepts_seen_o == '0))
    else $error("closed window left counters set");

  a_close_adapting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_closed_o |-> adapting_o)
    else $error("window closed while adaptation was off");

endmodule

bind adaptive_step_size_tuner asst_checker u_asst_checker (.*);
